// ===== src/multilevel_feedback_queue_scheduler_unit_assert.svh =====
// Assertion macros for the multilevel feedback queue scheduler.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef MULTILEVEL_FEEDBACK_QUEUE_SCHEDULER_UNIT_ASSERT_SVH
`define MULTILEVEL_FEEDBACK_QUEUE_SCHEDULER_UNIT_ASSERT_SVH

// The property must hold at every clock edge outside reset.
`define MFQS_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// The expression must never be true outside reset.
`define MFQS_NEVER(name, expr, msg) \
  name: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error(msg);

`endif

// ===== src/mfqs_pkg.sv =====
// Shared types and constants for the multilevel feedback queue scheduler.
// No dependencies; the scheduler RTL refers to this package by scoped names, the testbench imports it.
`timescale 1ns / 1ps

package mfqs_pkg;

  localparam int NUM_SLOTS  = 64;
  localparam int NUM_LEVELS = 3;

  localparam int SLOT_W     = $clog2(NUM_SLOTS);
  localparam int CNT_W      = $clog2(NUM_SLOTS + 1);
  localparam int LVL_W      = 2;
  localparam int QUANTA_W   = 8;
  localparam int PERIOD_W   = 8;
  localparam int CMD_W      = 2;

  // Queue storage is addressed as {level, index}.
  localparam int ENTRY_DEPTH = NUM_LEVELS * NUM_SLOTS;
  localparam int ENTRY_AW    = LVL_W + SLOT_W;

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  localparam logic [CMD_W-1:0] CMD_CREATE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_YIELD  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_WAKE   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_PICK   = 2'd3;

  localparam logic [LVL_W-1:0] LVL_HIGH = 2'd0;
  localparam logic [LVL_W-1:0] LVL_MID  = 2'd1;
  localparam logic [LVL_W-1:0] LVL_LOW  = 2'd2;

  localparam logic REG_DEMOTE_PERIOD = 1'b0;
  localparam logic REG_MULTI_LEVEL   = 1'b1;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 8'd5;
  localparam logic                MODE_RESET   = 1'b1;

  typedef struct packed {
    logic [CMD_W-1:0]    command;
    logic [SLOT_W-1:0]   slot;
    logic [QUANTA_W-1:0] quanta;
  } request_t;

  typedef struct packed {
    logic [SLOT_W-1:0] picked_slot;
    logic              picked_valid;
    logic [LVL_W-1:0]  level;
    logic              status;
  } result_t;

  typedef struct packed {
    logic                start;
    logic [QUANTA_W-1:0] dividend;
    logic [PERIOD_W-1:0] divisor;
  } mod_req_t;

  typedef struct packed {
    logic                done;
    logic [PERIOD_W-1:0] remainder;
  } mod_rsp_t;

endpackage

// ===== src/mfqs_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`timescale 1ns / 1ps

module mfqs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/mfqs_mod.sv =====
// Bit-serial remainder unit: one restoring step per cycle over the dividend.
// Depends on mfqs_pkg.
`timescale 1ns / 1ps

module mfqs_mod (
  input  logic              clk,
  input  logic              rst,
  input  mfqs_pkg::mod_req_t req,
  output mfqs_pkg::mod_rsp_t rsp
);

  localparam int STEP_W = $clog2(mfqs_pkg::QUANTA_W);

  logic                              run;
  logic                              done;
  logic [STEP_W-1:0]                 step;
  logic [mfqs_pkg::QUANTA_W-1:0]     shifter;
  logic [mfqs_pkg::PERIOD_W-1:0]     divisor;
  logic [mfqs_pkg::PERIOD_W-1:0]     rem;
  logic [mfqs_pkg::PERIOD_W:0]       trial;
  logic [mfqs_pkg::PERIOD_W-1:0]     rem_next;

  // A zero divisor always subtracts nothing, so the remainder ends as the dividend.
  always_comb begin
    trial = {rem, shifter[mfqs_pkg::QUANTA_W-1]};
    if (trial >= {1'b0, divisor}) begin
      trial = trial - {1'b0, divisor};
    end
    rem_next = trial[mfqs_pkg::PERIOD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else if (req.start) begin
      run     <= 1'b1;
      done    <= 1'b0;
      step    <= '0;
      shifter <= req.dividend;
      divisor <= req.divisor;
      rem     <= '0;
    end else if (run) begin
      rem     <= rem_next;
      shifter <= {shifter[mfqs_pkg::QUANTA_W-2:0], 1'b0};
      step    <= step + 1'b1;
      if (step == STEP_W'(mfqs_pkg::QUANTA_W - 1)) begin
        run  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  assign rsp.done      = done;
  assign rsp.remainder = rem;

endmodule

// ===== src/multilevel_feedback_queue_scheduler_unit.sv =====
// Top level of the multilevel feedback queue scheduler.
// Depends on mfqs_pkg, mfqs_ram, mfqs_mod and the assertion macro header.
//
//   Channel   Handshake                          Payload
//   command   start / busy (taken: start & !busy) request (mfqs_pkg::request_t)
//   result    done, one cycle, no back-pressure   result  (mfqs_pkg::result_t)
//   config    APB write, pready tied high         pwdata, paddr, prdata
//
// Create, wake and yield go through S_PRI_RD and S_PRI_WAIT; yield stays in S_PRI_WAIT
// until the remainder unit is done. Pick ends in S_PICK_RD when empty, else S_PICK_OUT.
// Queue storage and the priority table are RAMs with a registered read;
// each command is finished before the next is taken, so no access overlaps.
// Reset (rst, synchronous) empties all queues and loads register defaults.
// The receiver cannot stall; busy falls at the edge that raises done.
`timescale 1ns / 1ps

`include "multilevel_feedback_queue_scheduler_unit_assert.svh"

module multilevel_feedback_queue_scheduler_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  mfqs_pkg::request_t                  request,
  output logic                                done,
  output mfqs_pkg::result_t                   result,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [mfqs_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [mfqs_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [mfqs_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready
);

  typedef enum logic [4:0] {
    S_IDLE     = 5'b00001,
    S_PICK_RD  = 5'b00010,
    S_PICK_OUT = 5'b00100,
    S_PRI_RD   = 5'b01000,
    S_PRI_WAIT = 5'b10000
  } state_t;

  state_t state;

  logic [mfqs_pkg::PERIOD_W-1:0] demote_period;
  logic                          multi_level_mode;

  mfqs_pkg::request_t req;

  logic [mfqs_pkg::SLOT_W-1:0] heads  [mfqs_pkg::NUM_LEVELS];
  logic [mfqs_pkg::SLOT_W-1:0] tails  [mfqs_pkg::NUM_LEVELS];
  logic [mfqs_pkg::CNT_W-1:0]  counts [mfqs_pkg::NUM_LEVELS];

  logic [mfqs_pkg::LVL_W-1:0] pick_lv;
  logic [mfqs_pkg::LVL_W-1:0] pick_sel;
  logic                       pick_hit;

  logic                         entry_we;
  logic [mfqs_pkg::ENTRY_AW-1:0] entry_waddr;
  logic                         entry_re;
  logic [mfqs_pkg::ENTRY_AW-1:0] entry_raddr;
  logic [mfqs_pkg::SLOT_W-1:0]  entry_rdata;

  logic                       pri_we;
  logic                       pri_re;
  logic [mfqs_pkg::LVL_W-1:0] pri_rdata;
  logic [mfqs_pkg::LVL_W-1:0] pri_old;
  logic [mfqs_pkg::LVL_W-1:0] pri_new;

  logic [mfqs_pkg::LVL_W-1:0] push_lv;
  logic                       push_fire;
  logic                       push_full;
  logic                       slot_bad;
  logic                       cfg_write;

  mfqs_pkg::mod_req_t mod_req;
  mfqs_pkg::mod_rsp_t mod_rsp;

  assign busy      = (state != S_IDLE);
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    if (paddr[2] == mfqs_pkg::REG_MULTI_LEVEL) begin
      prdata = {{(mfqs_pkg::APB_DATA_W - 1){1'b0}}, multi_level_mode};
    end else begin
      prdata = {{(mfqs_pkg::APB_DATA_W - mfqs_pkg::PERIOD_W){1'b0}}, demote_period};
    end
  end

  assign slot_bad = ({1'b0, request.slot} >= mfqs_pkg::CNT_W'(mfqs_pkg::NUM_SLOTS));

  // Highest non-empty queue; single-queue mode looks only at the lowest level.
  always_comb begin
    pick_sel = mfqs_pkg::LVL_LOW;
    pick_hit = (counts[mfqs_pkg::LVL_LOW] != '0);
    if (multi_level_mode) begin
      if (counts[mfqs_pkg::LVL_HIGH] != '0) begin
        pick_sel = mfqs_pkg::LVL_HIGH;
        pick_hit = 1'b1;
      end else if (counts[mfqs_pkg::LVL_MID] != '0) begin
        pick_sel = mfqs_pkg::LVL_MID;
        pick_hit = 1'b1;
      end
    end
  end

  // A stored priority of three cannot arise but is treated as the lowest level.
  assign pri_old = (pri_rdata > mfqs_pkg::LVL_LOW) ? mfqs_pkg::LVL_LOW : pri_rdata;

  always_comb begin
    pri_new = pri_old;
    if (req.command == mfqs_pkg::CMD_CREATE) begin
      pri_new = mfqs_pkg::LVL_MID;
    end else if (multi_level_mode) begin
      if (req.command == mfqs_pkg::CMD_YIELD) begin
        if (mod_rsp.remainder == '0 && pri_old != mfqs_pkg::LVL_LOW) begin
          pri_new = pri_old + 1'b1;
        end
      end else if (pri_old != mfqs_pkg::LVL_HIGH) begin
        pri_new = pri_old - 1'b1;
      end
    end
  end

  assign push_lv   = multi_level_mode ? pri_new : mfqs_pkg::LVL_LOW;
  assign push_full = (counts[push_lv] >= mfqs_pkg::CNT_W'(mfqs_pkg::NUM_SLOTS));
  assign push_fire = (state == S_PRI_WAIT) &&
                     ((req.command != mfqs_pkg::CMD_YIELD) || mod_rsp.done);

  assign entry_re    = (state == S_PICK_RD) && pick_hit;
  assign entry_raddr = {pick_sel, heads[pick_sel]};
  assign entry_we    = push_fire && !push_full;
  assign entry_waddr = {push_lv, tails[push_lv]};

  assign pri_re = (state == S_PRI_RD);
  assign pri_we = push_fire && ((req.command == mfqs_pkg::CMD_CREATE) || multi_level_mode);

  assign mod_req.start    = (state == S_PRI_RD) && (req.command == mfqs_pkg::CMD_YIELD);
  assign mod_req.dividend = req.quanta;
  assign mod_req.divisor  = demote_period;

  mfqs_ram #(
    .WIDTH (mfqs_pkg::SLOT_W),
    .DEPTH (mfqs_pkg::ENTRY_DEPTH)
  ) u_entry_ram (
    .clk   (clk),
    .we    (entry_we),
    .waddr (entry_waddr),
    .wdata (req.slot),
    .re    (entry_re),
    .raddr (entry_raddr),
    .rdata (entry_rdata)
  );

  mfqs_ram #(
    .WIDTH (mfqs_pkg::LVL_W),
    .DEPTH (mfqs_pkg::NUM_SLOTS)
  ) u_pri_ram (
    .clk   (clk),
    .we    (pri_we),
    .waddr (req.slot),
    .wdata (pri_new),
    .re    (pri_re),
    .raddr (req.slot),
    .rdata (pri_rdata)
  );

  mfqs_mod u_mod (
    .clk (clk),
    .rst (rst),
    .req (mod_req),
    .rsp (mod_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      done             <= 1'b0;
      demote_period    <= mfqs_pkg::PERIOD_RESET;
      multi_level_mode <= mfqs_pkg::MODE_RESET;
      for (int i = 0; i < mfqs_pkg::NUM_LEVELS; i++) begin
        heads[i]  <= '0;
        tails[i]  <= '0;
        counts[i] <= '0;
      end
    end else begin
      done <= 1'b0;

      if (cfg_write) begin
        unique case (paddr[2])
          mfqs_pkg::REG_DEMOTE_PERIOD: demote_period <= pwdata[mfqs_pkg::PERIOD_W-1:0];
          mfqs_pkg::REG_MULTI_LEVEL:   multi_level_mode <= pwdata[0];
          default: ;
        endcase
      end

      unique case (state)
        S_IDLE: begin
          if (start) begin
            req <= request;
            if (request.command == mfqs_pkg::CMD_PICK) begin
              state <= S_PICK_RD;
            end else if (slot_bad) begin
              result <= '0;
              done   <= 1'b1;
            end else begin
              state <= S_PRI_RD;
            end
          end
        end
        S_PICK_RD: begin
          if (pick_hit) begin
            pick_lv <= pick_sel;
            state   <= S_PICK_OUT;
          end else begin
            result <= '0;
            done   <= 1'b1;
            state  <= S_IDLE;
          end
        end
        S_PICK_OUT: begin
          result <= '{picked_slot: entry_rdata, picked_valid: 1'b1,
                      level: pick_lv, status: 1'b0};
          heads[pick_lv]  <= heads[pick_lv] + 1'b1;
          counts[pick_lv] <= counts[pick_lv] - 1'b1;
          done  <= 1'b1;
          state <= S_IDLE;
        end
        S_PRI_RD: begin
          state <= S_PRI_WAIT;
        end
        S_PRI_WAIT: begin
          if (push_fire) begin
            if (!push_full) begin
              tails[push_lv]  <= tails[push_lv] + 1'b1;
              counts[push_lv] <= counts[push_lv] + 1'b1;
            end
            result <= '{picked_slot: '0, picked_valid: 1'b0,
                        level: push_lv, status: push_full};
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `MFQS_ASSERT(a_accept_goes_busy, (start && !busy) |=> (busy || done),
               "accepted command neither busy nor answered")
  `MFQS_ASSERT(a_single_result, done |=> !done,
               "two result transactions in consecutive cycles")
  `MFQS_NEVER(a_count_overflow,
              (counts[0] > mfqs_pkg::CNT_W'(mfqs_pkg::NUM_SLOTS)) ||
              (counts[1] > mfqs_pkg::CNT_W'(mfqs_pkg::NUM_SLOTS)) ||
              (counts[2] > mfqs_pkg::CNT_W'(mfqs_pkg::NUM_SLOTS)),
              "queue occupancy beyond capacity")
  `MFQS_NEVER(a_full_and_picked, done && result.status && result.picked_valid,
              "full flag on a pick result")
  `MFQS_ASSERT(a_pick_read_used, (state == S_PICK_OUT) |-> $past(entry_re),
               "pick output without a queue read")

endmodule

// ===== tb/mfqs_schedule_checker.sv =====
// Checker for the multilevel feedback queue scheduler: watches the command, result and
// register channels, predicts every result and compares it. Depends on mfqs_pkg only.
`timescale 1ns / 1ps

module mfqs_schedule_checker
  import mfqs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic                  busy,
  input  request_t              request,
  input  logic                  done,
  input  result_t               result,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  input  logic                  pready,
  output int                    outstanding,
  output int                    mismatches
);

  logic [SLOT_W-1:0]   ready_slots [NUM_LEVELS][NUM_SLOTS];
  int                  ready_head  [NUM_LEVELS];
  int                  ready_tail  [NUM_LEVELS];
  int                  ready_count [NUM_LEVELS];
  logic [LVL_W-1:0]    slot_level  [NUM_SLOTS];
  logic [PERIOD_W-1:0] period_cfg;
  logic                multi_cfg;
  result_t             expected_results [$];
  int                  error_total;
  int                  pending;

  assign outstanding = pending;
  assign mismatches  = error_total;

  initial begin
    error_total = 0;
    pending     = 0;
    period_cfg  = PERIOD_RESET;
    multi_cfg   = MODE_RESET;
    for (int i = 0; i < NUM_LEVELS; i++) begin
      ready_head[i]  = 0;
      ready_tail[i]  = 0;
      ready_count[i] = 0;
    end
    for (int i = 0; i < NUM_SLOTS; i++) slot_level[i] = LVL_HIGH;
  end

  // Applies one command to the predicted scheduler state and returns its result.
  function automatic result_t schedule_command(input request_t req);
    result_t             res;
    logic [LVL_W-1:0]    lvl;
    logic [PERIOD_W-1:0] rem;
    bit                  found;
    int                  idx;
    res   = '0;
    found = 0;
    if (req.command == CMD_PICK) begin
      for (int i = 0; i < NUM_LEVELS; i++) begin
        if (!found && (multi_cfg || i == LVL_LOW) && ready_count[i] != 0) begin
          found            = 1;
          res.picked_slot  = ready_slots[i][ready_head[i]];
          res.picked_valid = 1'b1;
          res.level        = LVL_W'(i);
          ready_head[i]    = (ready_head[i] + 1) % NUM_SLOTS;
          ready_count[i]--;
        end
      end
      return res;
    end
    idx = req.slot;
    lvl = slot_level[idx];
    if (lvl > LVL_LOW) lvl = LVL_LOW;
    if (req.command == CMD_CREATE) begin
      lvl             = LVL_MID;
      slot_level[idx] = LVL_MID;
    end else if (multi_cfg) begin
      if (req.command == CMD_YIELD) begin
        rem = (period_cfg != 0) ? req.quanta % period_cfg : req.quanta;
        if (rem == 0 && lvl != LVL_LOW) lvl = lvl + 1'b1;
      end else if (lvl != LVL_HIGH) begin
        lvl = lvl - 1'b1;
      end
      slot_level[idx] = lvl;
    end
    if (!multi_cfg) lvl = LVL_LOW;
    res.level = lvl;
    if (ready_count[lvl] >= NUM_SLOTS) begin
      res.status = 1'b1;
    end else begin
      ready_slots[lvl][ready_tail[lvl]] = req.slot;
      ready_tail[lvl] = (ready_tail[lvl] + 1) % NUM_SLOTS;
      ready_count[lvl]++;
    end
    return res;
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (!rst) begin
      // Results are compared before a new command is predicted in the same cycle.
      if (done) begin
        if (expected_results.size() == 0) begin
          $error("result transaction with no command outstanding");
          error_total++;
        end else begin
          want = expected_results.pop_front();
          pending--;
          if (result.picked_slot !== want.picked_slot) begin
            $error("picked_slot: expected %0d, actual %0d", want.picked_slot,
                   result.picked_slot);
            error_total++;
          end
          if (result.picked_valid !== want.picked_valid) begin
            $error("picked_valid: expected %0d, actual %0d", want.picked_valid,
                   result.picked_valid);
            error_total++;
          end
          if (result.level !== want.level) begin
            $error("level: expected %0d, actual %0d", want.level, result.level);
            error_total++;
          end
          if (result.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, result.status);
            error_total++;
          end
        end
      end
      if (start && !busy) begin
        expected_results.push_back(schedule_command(request));
        pending++;
      end
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_DEMOTE_PERIOD) period_cfg = pwdata[PERIOD_W-1:0];
        else multi_cfg = pwdata[0];
      end
    end
  end

endmodule

// ===== tb/tb_multilevel_feedback_queue_scheduler_unit.sv =====
// Top of the scheduler testbench: clock, reset, command and register stimulus, verdict.
// Depends on mfqs_pkg, the scheduler RTL and mfqs_schedule_checker.
`timescale 1ns / 1ps

module tb_multilevel_feedback_queue_scheduler_unit;
  import mfqs_pkg::*;

  localparam int RANDOM_ITEMS = 1050;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int DRAIN_CYCLES = 20;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  start;
  logic                  busy;
  request_t              request;
  logic                  done;
  result_t               result;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  int                    outstanding;
  int                    mismatches;
  int                    cycles = 0;

  bit                  created [NUM_SLOTS];
  bit                  any_created;
  bit                  no_gaps;
  logic [PERIOD_W-1:0] period_now;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  multilevel_feedback_queue_scheduler_unit dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .request(request), .done(done),
    .result(result), .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  mfqs_schedule_checker checker_i (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .request(request), .done(done),
    .result(result), .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready), .outstanding(outstanding), .mismatches(mismatches)
  );

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Called at a falling edge; returns at the falling edge after the command is taken.
  task automatic issue(input logic [CMD_W-1:0] cmd, input int slot, input int quanta);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 10);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start           <= 1'b1;
    request.command <= cmd;
    request.slot    <= SLOT_W'(slot);
    request.quanta  <= QUANTA_W'(quanta);
    if (cmd == CMD_CREATE) begin
      created[slot] = 1;
      any_created   = 1;
    end
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  task automatic settle();
    start <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  // The bus goes idle after each write before the next transfer starts.
  task automatic write_reg(input logic idx, input logic [APB_DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_DEMOTE_PERIOD) period_now = value[PERIOD_W-1:0];
    @(negedge clk);
  endtask

  task automatic configure(input int period, input bit multi);
    settle();
    write_reg(REG_DEMOTE_PERIOD, APB_DATA_W'(period));
    write_reg(REG_MULTI_LEVEL, APB_DATA_W'(multi));
  endtask

  // One random command; pick_pct sets how often the ready queues are drained.
  task automatic random_command(input int pick_pct);
    int slot;
    int quanta;
    int roll;
    roll = $urandom_range(0, 99);
    slot = $urandom_range(0, NUM_SLOTS - 1);
    if (roll < pick_pct) begin
      issue(CMD_PICK, slot, $urandom_range(0, 255));
    end else if (!any_created || roll % 3 == 0) begin
      issue(CMD_CREATE, slot, $urandom_range(0, 255));
    end else begin
      // A priority entry is only ever read for a slot that has been created.
      while (!created[slot]) slot = $urandom_range(0, NUM_SLOTS - 1);
      if ($urandom_range(0, 1) == 0 || period_now == 0)
        quanta = $urandom_range(0, 255);
      else
        quanta = period_now * $urandom_range(0, 255 / period_now);
      issue(roll % 3 == 1 ? CMD_YIELD : CMD_WAKE, slot, quanta);
    end
  endtask

  initial begin
    int sent;
    int count;
    int style;
    int pick_pct;
    int period;
    rst         = 1'b1;
    start       = 1'b0;
    request     = '0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    any_created = 0;
    no_gaps     = 0;
    period_now  = PERIOD_RESET;
    for (int i = 0; i < NUM_SLOTS; i++) created[i] = 0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part with the reset configuration: empty pick, demotion at the bottom
    // level, promotion at the top level, and a partial drain.
    issue(CMD_PICK, NUM_SLOTS - 1, 255);
    issue(CMD_CREATE, 0, 0);
    issue(CMD_CREATE, NUM_SLOTS - 1, 255);
    issue(CMD_YIELD, NUM_SLOTS - 1, 0);
    issue(CMD_YIELD, NUM_SLOTS - 1, 0);
    issue(CMD_YIELD, 0, 7);
    issue(CMD_WAKE, NUM_SLOTS - 1, 0);
    issue(CMD_WAKE, NUM_SLOTS - 1, 0);
    issue(CMD_WAKE, NUM_SLOTS - 1, 0);
    issue(CMD_YIELD, 0, 255);
    repeat (6) issue(CMD_PICK, 0, 0);
    // A zero period demotes only on zero quanta.
    configure(0, 1);
    issue(CMD_YIELD, 0, 0);
    issue(CMD_YIELD, 0, 1);
    // Single-queue mode: everything goes through the lowest queue.
    configure(255, 0);
    issue(CMD_CREATE, 5, 0);
    issue(CMD_YIELD, 5, 0);
    issue(CMD_WAKE, 5, 0);
    issue(CMD_PICK, 0, 0);

    // The first random phase overfills the lowest queue in single-queue mode.
    configure(1, 0);
    for (int i = 0; i < 110; i++) random_command(5);
    sent = 110;
    while (sent < RANDOM_ITEMS) begin
      style = $urandom_range(0, 3);
      case ($urandom_range(0, 9))
        0: period = 0;
        1: period = 1;
        2: period = 255;
        default: period = $urandom_range(1, 255);
      endcase
      configure(period, $urandom_range(0, 9) < 7);
      no_gaps  = ($urandom_range(0, 3) == 0);
      pick_pct = (style == 0) ? 5 : (style == 1) ? 70 : 40;
      count    = (style == 0) ? $urandom_range(70, 130) : $urandom_range(40, 120);
      for (int i = 0; i < count; i++) random_command(pick_pct);
      sent += count;
    end

    settle();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+src
src/mfqs_pkg.sv
src/mfqs_ram.sv
src/mfqs_mod.sv
src/multilevel_feedback_queue_scheduler_unit.sv
tb/mfqs_schedule_checker.sv
tb/tb_multilevel_feedback_queue_scheduler_unit.sv
